>>> rtl/ste_pkg.sv
package ste_pkg;

  localparam int MAX_SAMPLES_DEF   = 4096;
  localparam int MAX_CHUNKS_DEF    = 1024;
  localparam int MAX_MAP_ROWS_DEF  = 256;
  localparam int MAX_TIME_ROWS_DEF = 256;

  localparam int TIME_W = 44;
  localparam int PADDR_W = 3;

  localparam logic REG_UNIFORM_SIZE = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  localparam logic [2:0] MODE_RESTART = 3'd0;
  localparam logic [2:0] MODE_SIZE    = 3'd1;
  localparam logic [2:0] MODE_MAP     = 3'd2;
  localparam logic [2:0] MODE_CHUNK   = 3'd3;
  localparam logic [2:0] MODE_TIME    = 3'd4;
  localparam logic [2:0] MODE_SYNC    = 3'd5;
  localparam logic [2:0] MODE_NEXT    = 3'd6;

  typedef enum logic [2:0] {
    OP_RESTART, OP_SIZE, OP_MAP, OP_CHUNK, OP_TIME, OP_SYNC, OP_NEXT, OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] a;
    logic [31:0] b;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_MAPW, ST_MAPCHK, ST_CHUNK, ST_RUNW, ST_RUN, ST_OUT
  } state_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> rtl/ste_ram.sv
module ste_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ste_front.sv
module ste_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    mode,
  input  logic [63:0]   value_a,
  input  logic [31:0]   value_b,
  output logic          q_valid,
  input  logic          q_ready,
  output ste_pkg::item_t q_item
);
  import ste_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      cls;

  always_comb begin
    cls.a = value_a;
    cls.b = value_b;
    unique case (mode)
      MODE_RESTART: cls.op = OP_RESTART;
      MODE_SIZE:    cls.op = OP_SIZE;
      MODE_MAP:     cls.op = OP_MAP;
      MODE_CHUNK:   cls.op = OP_CHUNK;
      MODE_TIME:    cls.op = OP_TIME;
      MODE_SYNC:    cls.op = OP_SYNC;
      MODE_NEXT:    cls.op = OP_NEXT;
      default:      cls.op = OP_NOP;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/ste_back.sv
module ste_back #(
  parameter int MAX_SAMPLES   = ste_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_CHUNKS    = ste_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_MAP_ROWS  = ste_pkg::MAX_MAP_ROWS_DEF,
  parameter int MAX_TIME_ROWS = ste_pkg::MAX_TIME_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  ste_pkg::item_t q_item,
  input  logic [31:0]    uniform_size,
  input  logic [12:0]    sample_count,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [11:0]    sample_index,
  output logic [31:0]    sample_size,
  output logic [63:0]    sample_offset,
  output logic [43:0]    decode_time,
  output logic           is_keyframe,
  output logic [12:0]    total_samples
);
  import ste_pkg::*;

  localparam int SA = addr_w(MAX_SAMPLES);
  localparam int CA = addr_w(MAX_CHUNKS);
  localparam int MA = addr_w(MAX_MAP_ROWS);
  localparam int RA = addr_w(MAX_TIME_ROWS);
  localparam int SC = $clog2(MAX_SAMPLES + 1);
  localparam int CC = $clog2(MAX_CHUNKS + 1);
  localparam int MC = $clog2(MAX_MAP_ROWS + 1);
  localparam int RC = $clog2(MAX_TIME_ROWS + 1);
  localparam logic [SA-1:0] CLR_LAST = SA'(MAX_SAMPLES - 1);

  state_t state, state_next;
  logic [SC-1:0] size_cnt, size_cnt_next;
  logic [MC-1:0] map_cnt, map_cnt_next;
  logic [CC-1:0] chunk_cnt, chunk_cnt_next;
  logic [RC-1:0] run_cnt, run_cnt_next;
  logic          any_sync, any_sync_next;
  logic [SC-1:0] idx, idx_next;
  logic [MC-1:0] map_ptr, map_ptr_next;
  logic [31:0]   spc, spc_next;
  logic [CC-1:0] chunk, chunk_next;
  logic [SC-1:0] sic, sic_next;
  logic [RC-1:0] rp, rp_next;
  logic [SC-1:0] ris, ris_next;
  logic [63:0]   run_off, run_off_next;
  logic [43:0]   run_time, run_time_next;
  logic [SA-1:0] clr_ptr, clr_ptr_next;
  logic [63:0]   offset_r, offset_r_next;
  logic [43:0]   dts_r, dts_r_next;
  logic          out_valid_next;
  logic          out_load;

  logic          size_we, map_we, chunk_we, run_we, key_we, key_wdata;
  logic [SA-1:0] key_waddr;
  logic [31:0]   size_rd;
  logic [63:0]   map_rd, chunk_rd, run_rd;
  logic          key_rd;
  logic [31:0]   total32;
  logic [31:0]   size_val;
  logic [31:0]   spc_val;

  ste_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_size (
    .clk(clk), .we(size_we), .waddr(size_cnt[SA-1:0]), .wdata(q_item.a[31:0]),
    .raddr(idx[SA-1:0]), .rdata(size_rd));

  ste_ram #(.WIDTH(64), .DEPTH(MAX_MAP_ROWS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_cnt[MA-1:0]), .wdata({q_item.a[31:0], q_item.b}),
    .raddr(map_ptr[MA-1:0]), .rdata(map_rd));

  ste_ram #(.WIDTH(64), .DEPTH(MAX_CHUNKS)) u_chunk (
    .clk(clk), .we(chunk_we), .waddr(chunk_cnt[CA-1:0]), .wdata(q_item.a),
    .raddr(chunk[CA-1:0]), .rdata(chunk_rd));

  ste_ram #(.WIDTH(64), .DEPTH(MAX_TIME_ROWS)) u_run (
    .clk(clk), .we(run_we), .waddr(run_cnt[RA-1:0]), .wdata({q_item.a[31:0], q_item.b}),
    .raddr(rp[RA-1:0]), .rdata(run_rd));

  ste_ram #(.WIDTH(1), .DEPTH(MAX_SAMPLES)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(idx[SA-1:0]), .rdata(key_rd));

  assign total32 = (32'(sample_count) > 32'(MAX_SAMPLES)) ? 32'(MAX_SAMPLES)
                                                          : 32'(sample_count);
  assign spc_val = spc;

  always_comb begin
    if (uniform_size != 32'd0) begin
      size_val = uniform_size;
    end else if (idx < size_cnt) begin
      size_val = size_rd;
    end else begin
      size_val = 32'd0;
    end
  end

  assign q_ready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    size_cnt_next  = size_cnt;
    map_cnt_next   = map_cnt;
    chunk_cnt_next = chunk_cnt;
    run_cnt_next   = run_cnt;
    any_sync_next  = any_sync;
    idx_next       = idx;
    map_ptr_next   = map_ptr;
    spc_next       = spc;
    chunk_next     = chunk;
    sic_next       = sic;
    rp_next        = rp;
    ris_next       = ris;
    run_off_next   = run_off;
    run_time_next  = run_time;
    clr_ptr_next   = clr_ptr;
    offset_r_next  = offset_r;
    dts_r_next     = dts_r;
    size_we        = 1'b0;
    map_we         = 1'b0;
    chunk_we       = 1'b0;
    run_we         = 1'b0;
    key_we         = 1'b0;
    key_wdata      = 1'b0;
    key_waddr      = clr_ptr;
    out_valid_next = out_valid && !out_ready;

    unique case (state)
      ST_CLR: begin
        key_we       = 1'b1;
        clr_ptr_next = clr_ptr + 1'b1;
        if (clr_ptr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_RESTART: begin
              size_cnt_next  = '0;
              map_cnt_next   = '0;
              chunk_cnt_next = '0;
              run_cnt_next   = '0;
              any_sync_next  = 1'b0;
              idx_next       = '0;
              map_ptr_next   = '0;
              spc_next       = 32'd1;
              chunk_next     = '0;
              sic_next       = '0;
              rp_next        = '0;
              ris_next       = '0;
              run_off_next   = '0;
              run_time_next  = '0;
              clr_ptr_next   = '0;
              state_next     = ST_CLR;
            end
            OP_SIZE: begin
              if (size_cnt < SC'(MAX_SAMPLES)) begin
                size_we       = 1'b1;
                size_cnt_next = size_cnt + 1'b1;
              end
            end
            OP_MAP: begin
              if (map_cnt < MC'(MAX_MAP_ROWS)) begin
                map_we       = 1'b1;
                map_cnt_next = map_cnt + 1'b1;
              end
            end
            OP_CHUNK: begin
              if (chunk_cnt < CC'(MAX_CHUNKS)) begin
                chunk_we       = 1'b1;
                chunk_cnt_next = chunk_cnt + 1'b1;
              end
            end
            OP_TIME: begin
              if (run_cnt < RC'(MAX_TIME_ROWS)) begin
                run_we       = 1'b1;
                run_cnt_next = run_cnt + 1'b1;
              end
            end
            OP_SYNC: begin
              any_sync_next = 1'b1;
              if (q_item.a >= 64'd1 && q_item.a <= 64'(MAX_SAMPLES)) begin
                key_we    = 1'b1;
                key_wdata = 1'b1;
                key_waddr = SA'(q_item.a - 64'd1);
              end
            end
            OP_NEXT: begin
              if (32'(idx) < total32) begin
                state_next = ST_MAPW;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAPW: state_next = ST_MAPCHK;
      ST_MAPCHK: begin
        if (map_ptr < map_cnt &&
            {1'b0, map_rd[63:32]} <= (33'(chunk) + 33'd1)) begin
          spc_next     = map_rd[31:0];
          map_ptr_next = map_ptr + 1'b1;
          state_next   = ST_MAPW;
        end else begin
          state_next = ST_CHUNK;
        end
      end
      ST_CHUNK: begin
        if (chunk >= chunk_cnt) begin
          offset_r_next = 64'd0;
          state_next    = ST_RUN;
        end else if (32'(sic) < spc_val) begin
          offset_r_next = (sic == '0) ? chunk_rd : run_off;
          run_off_next  = offset_r_next + 64'(size_val);
          sic_next      = sic + 1'b1;
          state_next    = ST_RUN;
        end else begin
          chunk_next = chunk + 1'b1;
          sic_next   = '0;
          state_next = ST_MAPW;
        end
      end
      ST_RUNW: state_next = ST_RUN;
      ST_RUN: begin
        if (rp < run_cnt && 32'(ris) >= run_rd[63:32]) begin
          rp_next    = rp + 1'b1;
          ris_next   = '0;
          state_next = ST_RUNW;
        end else begin
          dts_r_next = run_time;
          if (rp < run_cnt) begin
            run_time_next = run_time + 44'(run_rd[31:0]);
            ris_next      = ris + 1'b1;
          end
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_next = 1'b1;
          idx_next       = idx + 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_index  <= 12'(idx);
      sample_size   <= size_val;
      sample_offset <= offset_r;
      decode_time   <= dts_r;
      is_keyframe   <= any_sync ? key_rd : 1'b1;
      total_samples <= 13'(total32);
    end
    offset_r <= offset_r_next;
    dts_r    <= dts_r_next;
    if (rst) begin
      state     <= ST_CLR;
      out_valid <= 1'b0;
      size_cnt  <= '0;
      map_cnt   <= '0;
      chunk_cnt <= '0;
      run_cnt   <= '0;
      any_sync  <= 1'b0;
      idx       <= '0;
      map_ptr   <= '0;
      spc       <= 32'd1;
      chunk     <= '0;
      sic       <= '0;
      rp        <= '0;
      ris       <= '0;
      run_off   <= '0;
      run_time  <= '0;
      clr_ptr   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      size_cnt  <= size_cnt_next;
      map_cnt   <= map_cnt_next;
      chunk_cnt <= chunk_cnt_next;
      run_cnt   <= run_cnt_next;
      any_sync  <= any_sync_next;
      idx       <= idx_next;
      map_ptr   <= map_ptr_next;
      spc       <= spc_next;
      chunk     <= chunk_next;
      sic       <= sic_next;
      rp        <= rp_next;
      ris       <= ris_next;
      run_off   <= run_off_next;
      run_time  <= run_time_next;
      clr_ptr   <= clr_ptr_next;
    end
  end

endmodule

>>> rtl/sample_table_expander.sv
// Table loads (size, map row, chunk offset, time row, sync) are taken by the back end while idle.
// Next request: ST_MAPW, ST_MAPCHK (repeated per map row crossed), ST_CHUNK (back to ST_MAPW
// per chunk skipped or finished), ST_RUN (via ST_RUNW per time row finished), then ST_OUT; the
// wait states cover the registered read of the table RAMs. The back end runs one next request at a time.
// Restart and reset: the keyframe bitmap is cleared over all MAX_SAMPLES (4096 by default) entries,
// during which queued transactions wait. Reset is synchronous, active high; counters go to 0.
module sample_table_expander #(
  parameter int MAX_SAMPLES   = ste_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_CHUNKS    = ste_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_MAP_ROWS  = ste_pkg::MAX_MAP_ROWS_DEF,
  parameter int MAX_TIME_ROWS = ste_pkg::MAX_TIME_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ste_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  mode,
  input  logic [63:0]                 value_a,
  input  logic [31:0]                 value_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [11:0]                 sample_index,
  output logic [31:0]                 sample_size,
  output logic [63:0]                 sample_offset,
  output logic [43:0]                 decode_time,
  output logic                        is_keyframe,
  output logic [12:0]                 total_samples
);
  import ste_pkg::*;

  logic [31:0] uniform_size;
  logic [12:0] sample_count;
  logic        q_valid;
  logic        q_ready;
  item_t       q_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SAMPLE_COUNT) ? {19'd0, sample_count} : uniform_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      uniform_size <= '0;
      sample_count <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_UNIFORM_SIZE: uniform_size <= pwdata;
        REG_SAMPLE_COUNT: sample_count <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  ste_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .value_a(value_a), .value_b(value_b),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

  ste_back #(
    .MAX_SAMPLES(MAX_SAMPLES), .MAX_CHUNKS(MAX_CHUNKS),
    .MAX_MAP_ROWS(MAX_MAP_ROWS), .MAX_TIME_ROWS(MAX_TIME_ROWS)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .uniform_size(uniform_size), .sample_count(sample_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_index(sample_index), .sample_size(sample_size),
    .sample_offset(sample_offset), .decode_time(decode_time),
    .is_keyframe(is_keyframe), .total_samples(total_samples));

endmodule

>>> rtl/ste_checker.sv
module ste_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] sample_index,
  input logic [12:0] total_samples
);

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_index))
    else $error("result dropped while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, sample_index} < total_samples))
    else $error("sample index past total");

endmodule

bind sample_table_expander ste_checker u_ste_checker (
  .clk(clk), .rst(rst), .pready(pready), .out_valid(out_valid),
  .out_ready(out_ready), .sample_index(sample_index), .total_samples(total_samples));

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ste_pkg::*;

  localparam int N_SAMP  = MAX_SAMPLES_DEF;
  localparam int N_CHUNK = MAX_CHUNKS_DEF;
  localparam int N_MAP   = MAX_MAP_ROWS_DEF;
  localparam int N_RUN   = MAX_TIME_ROWS_DEF;
  localparam int SETTLE  = 6000;
  localparam int STALL_LIMIT = 30000;

  typedef struct {
    logic [11:0] index;
    logic [31:0] size;
    logic [63:0] offset;
    logic [43:0] dts;
    logic        key;
    logic [12:0] total;
  } sample_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode = MODE_RESTART;
  logic [63:0] value_a = '0;
  logic [31:0] value_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] sample_index;
  logic [31:0] sample_size;
  logic [63:0] sample_offset;
  logic [43:0] decode_time;
  logic        is_keyframe;
  logic [12:0] total_samples;

  sample_table_expander u_dut (.*);

  // predictor state
  logic [31:0] cfg_uniform;
  logic [12:0] cfg_count;
  logic [31:0] sizes [N_SAMP];
  logic [31:0] map_first [N_MAP];
  logic [31:0] map_spc [N_MAP];
  logic [63:0] chunk_base [N_CHUNK];
  logic [31:0] run_len [N_RUN];
  logic [31:0] run_delta [N_RUN];
  bit          key_map [N_SAMP];
  int unsigned n_size, n_map, n_chunk, n_run, n_sync, n_emit;
  int unsigned cur_chunk, cur_in_chunk, cur_run, cur_in_run;
  logic [63:0] run_offset;
  logic [43:0] run_time;

  item_t       pending [$];
  sample_rec_t expected_recs [$];
  int          mismatches = 0;
  int          emitted = 0;
  bit          calm = 1'b0;
  bit          stall_done = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  initial forever #4 clk = ~clk;

  function automatic void clear_walk();
    n_size = 0; n_map = 0; n_chunk = 0; n_run = 0; n_sync = 0; n_emit = 0;
    cur_chunk = 0; cur_in_chunk = 0; cur_run = 0; cur_in_run = 0;
    run_offset = '0;
    run_time = '0;
    foreach (key_map[i]) key_map[i] = 1'b0;
  endfunction

  function automatic logic [31:0] spc_for(int unsigned c);
    logic [31:0] spc;
    spc = 32'd1;
    for (int unsigned r = 0; r < n_map; r++) begin
      if ({1'b0, map_first[r]} <= 33'(c) + 33'd1) spc = map_spc[r];
      else break;
    end
    return spc;
  endfunction

  function automatic bit expand_step(input logic [2:0] m, input logic [63:0] a,
                                     input logic [31:0] b, output sample_rec_t r);
    int unsigned total, idx;
    logic [31:0] sz;
    logic [63:0] off;
    r = '{default: '0};
    case (op_t'(m))
      OP_RESTART: clear_walk();
      OP_SIZE: if (n_size < N_SAMP) begin
        sizes[n_size] = a[31:0];
        n_size++;
      end
      OP_MAP: if (n_map < N_MAP) begin
        map_first[n_map] = a[31:0];
        map_spc[n_map] = b;
        n_map++;
      end
      OP_CHUNK: if (n_chunk < N_CHUNK) begin
        chunk_base[n_chunk] = a;
        n_chunk++;
      end
      OP_TIME: if (n_run < N_RUN) begin
        run_len[n_run] = a[31:0];
        run_delta[n_run] = b;
        n_run++;
      end
      OP_SYNC: begin
        if (a >= 64'd1 && a <= 64'(N_SAMP)) key_map[a - 64'd1] = 1'b1;
        if (n_sync < 8191) n_sync++;
      end
      default: ;
    endcase
    if (op_t'(m) != OP_NEXT) return 1'b0;
    total = (cfg_count > N_SAMP) ? N_SAMP : cfg_count;
    idx = n_emit;
    if (idx >= total) return 1'b0;
    if (cfg_uniform != 0) sz = cfg_uniform;
    else if (idx < n_size) sz = sizes[idx];
    else sz = '0;
    off = '0;
    while (1) begin
      if (cur_chunk >= n_chunk) begin
        off = '0;
        break;
      end
      if (cur_in_chunk < spc_for(cur_chunk)) begin
        if (cur_in_chunk == 0) run_offset = chunk_base[cur_chunk];
        off = run_offset;
        run_offset = run_offset + 64'(sz);
        cur_in_chunk++;
        break;
      end
      cur_chunk++;
      cur_in_chunk = 0;
    end
    while (cur_run < n_run && cur_in_run >= run_len[cur_run]) begin
      cur_run++;
      cur_in_run = 0;
    end
    r.dts = run_time;
    if (cur_run < n_run) begin
      run_time = run_time + 44'(run_delta[cur_run]);
      cur_in_run++;
    end
    r.index = idx[11:0];
    r.size = sz;
    r.offset = off;
    r.key = (n_sync == 0) ? 1'b1 : key_map[idx];
    r.total = total[12:0];
    n_emit++;
    return 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    item_t it;
    sample_rec_t rec;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (expand_step(mode, value_a, value_b, rec)) expected_recs.push_back(rec);
      end
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 10)) begin
          it = pending.pop_front();
          in_valid <= 1'b1;
          mode <= it.op;
          value_a <= it.a;
          value_b <= it.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sample_rec_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        emitted++;
        if (expected_recs.size() == 0) begin
          $error("unexpected transaction index=%0d", sample_index);
          mismatches++;
        end else begin
          e = expected_recs.pop_front();
          if (sample_index !== e.index) begin
            $error("sample_index exp %0d got %0d", e.index, sample_index); mismatches++;
          end
          if (sample_size !== e.size) begin
            $error("sample_size exp %0h got %0h", e.size, sample_size); mismatches++;
          end
          if (sample_offset !== e.offset) begin
            $error("sample_offset exp %0h got %0h", e.offset, sample_offset); mismatches++;
          end
          if (decode_time !== e.dts) begin
            $error("decode_time exp %0h got %0h", e.dts, decode_time); mismatches++;
          end
          if (is_keyframe !== e.key) begin
            $error("is_keyframe exp %0b got %0b", e.key, is_keyframe); mismatches++;
          end
          if (total_samples !== e.total) begin
            $error("total_samples exp %0d got %0d", e.total, total_samples); mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!stall_done && emitted >= 40 && pending.size() > 8) begin
        stall_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (pending.size() == 0 && !in_valid && expected_recs.size() == 0))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic add(input op_t op, input logic [63:0] a, input logic [31:0] b);
    item_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    pending.push_back(it);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_UNIFORM_SIZE) cfg_uniform = data;
    else cfg_count = data[12:0];
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected_recs.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int queued, nsz, k, cnt, pick;
    logic [31:0] fc;
    cfg_uniform = '0;
    cfg_count = '0;
    clear_walk();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed
    reg_write(REG_UNIFORM_SIZE, 32'd0);
    reg_write(REG_SAMPLE_COUNT, 32'hFFFF_FFFF);
    add(OP_RESTART, 64'd0, 32'd0);
    add(OP_SIZE, 64'd0, 32'd0);
    add(OP_SIZE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    add(OP_SIZE, 64'd5, 32'd0);
    add(OP_MAP, 64'd1, 32'd2);
    add(OP_MAP, 64'd2, 32'd0);
    add(OP_MAP, 64'd3, 32'd1);
    add(OP_CHUNK, 64'd0, 32'd0);
    add(OP_CHUNK, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    add(OP_TIME, 64'd2, 32'hFFFF_FFFF);
    add(OP_TIME, 64'd0, 32'd5);
    add(OP_TIME, 64'd1, 32'd7);
    add(OP_SYNC, 64'd0, 32'd0);
    add(OP_SYNC, 64'd2, 32'd0);
    add(OP_SYNC, 64'd5000, 32'd0);
    add(OP_SYNC, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    add(OP_NOP, 64'd1, 32'd1);
    for (int i = 0; i < 6; i++) add(OP_NEXT, 64'd0, 32'd0);
    queued = pending.size();
    drain();

    // capacity: overflow of map and time tables, all-ones uniform size
    reg_write(REG_UNIFORM_SIZE, 32'hFFFF_FFFF);
    reg_write(REG_SAMPLE_COUNT, 32'd0);
    reg_write(REG_SAMPLE_COUNT, 32'd4096);
    add(OP_RESTART, 64'd0, 32'd0);
    for (int i = 0; i < N_MAP + 2; i++) add(OP_MAP, 64'd1, (i >= N_MAP) ? 32'd3 : 32'd2);
    for (int i = 0; i < N_RUN + 2; i++) add(OP_TIME, 64'd1, 32'(i + 1));
    add(OP_CHUNK, 64'h8000_0000_0000_0000, 32'd0);
    for (int i = 0; i < 4; i++) add(OP_NEXT, 64'd0, 32'd0);
    queued += pending.size();
    drain();

    for (int ph = 0; queued < 1900; ph++) begin
      calm = (ph == 3);
      nsz = $urandom_range(0, 30);
      pick = $urandom_range(0, 9);
      cnt = (pick == 0) ? 0 : (pick == 1) ? 4096 : (pick == 2) ? 8191 :
            nsz + $urandom_range(0, 3);
      reg_write(REG_SAMPLE_COUNT, {$urandom_range(0, 1) ? $urandom : 32'd0} & 32'hFFFF_E000
                | 32'(cnt));
      pick = $urandom_range(0, 3);
      reg_write(REG_UNIFORM_SIZE, (pick < 2) ? 32'd0 : (pick == 2) ? $urandom : 32'hFFFF_FFFF);
      add(OP_RESTART, rand64(), $urandom);
      for (int i = 0; i < nsz; i++) add(OP_SIZE, rand64(), $urandom);
      k = $urandom_range(0, 4);
      fc = 1;
      for (int i = 0; i < k; i++) begin
        add(OP_MAP, $urandom_range(0, 9) == 0 ? rand64() : {$urandom, fc},
            $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 4));
        fc += $urandom_range(0, 3);
      end
      k = $urandom_range(0, 8);
      for (int i = 0; i < k; i++) add(OP_CHUNK, rand64(), $urandom);
      k = $urandom_range(0, 4);
      for (int i = 0; i < k; i++)
        add(OP_TIME, {$urandom, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 5)},
            $urandom);
      k = $urandom_range(0, 5);
      for (int i = 0; i < k; i++)
        add(OP_SYNC, $urandom_range(0, 7) == 0 ? rand64() : 64'($urandom_range(0, nsz + 2)),
            $urandom);
      for (int i = 0; i < nsz + 3; i++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) add(op_t'($urandom_range(1, 5)), 64'($urandom_range(0, 40)),
                           $urandom_range(0, 3));
        else if (pick == 1) add(OP_NOP, rand64(), $urandom);
        add(OP_NEXT, rand64(), $urandom);
      end
      queued += pending.size();
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && expected_recs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ste_pkg.sv
rtl/ste_ram.sv
rtl/ste_front.sv
rtl/ste_back.sv
rtl/sample_table_expander.sv
rtl/ste_checker.sv
test/tb_top.sv
